// ===== design/button_click_classifier_top_macros.svh =====
// Assertion macros used by the button click classifier checker.
`ifndef BUTTON_CLICK_CLASSIFIER_TOP_MACROS_SVH
`define BUTTON_CLICK_CLASSIFIER_TOP_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define BCC_ASSERT_NOW(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("button click classifier check failed");

// Next-cycle implication, disabled during reset.
`define BCC_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("button click classifier check failed");

`endif

// ===== design/bcc_pkg.sv =====
// Types, constants and register codes of the button click classifier.
`timescale 1ns / 1ps

package bcc_pkg;

   localparam int DEF_BUTTON_COUNT = 8;
   localparam int DEF_COUNT_WIDTH  = 19;
   localparam int MASK_WIDTH       = 8;
   localparam int TICK_REG_WIDTH   = 19;
   localparam int CSR_ADDR_WIDTH   = 5;
   localparam int CSR_DATA_WIDTH   = 32;

   localparam logic [TICK_REG_WIDTH-1:0] CLICK_TICKS_RESET  = 19'd5;
   localparam logic [TICK_REG_WIDTH-1:0] LONG_TICKS_RESET   = 19'd100;
   localparam logic [TICK_REG_WIDTH-1:0] VLONG_TICKS_RESET  = 19'd300;
   localparam logic [TICK_REG_WIDTH-1:0] WINDOW_TICKS_RESET = 19'd50;
   localparam logic [3:0]                REPEAT_MAX         = 4'd15;

   typedef enum logic [2:0] {
      REG_ENABLED = 3'd0,
      REG_ACTIVE  = 3'd1,
      REG_PAUSED  = 3'd2,
      REG_CLICK   = 3'd3,
      REG_LONG    = 3'd4,
      REG_VLONG   = 3'd5,
      REG_WINDOW  = 3'd6
   } bcc_reg_type;

   typedef enum logic [2:0] {
      EV_PRESS           = 3'd0,
      EV_LONG_PRESS      = 3'd1,
      EV_VERY_LONG_PRESS = 3'd2,
      EV_CLICK           = 3'd3,
      EV_LONG_CLICK      = 3'd4,
      EV_VERY_LONG_CLICK = 3'd5
   } bcc_kind_type;

   typedef struct packed {
      logic [2:0]   button_index;
      bcc_kind_type event_kind;
      logic [3:0]   click_count;
   } bcc_event_type;

   typedef struct packed {
      bcc_event_type ev;
      logic          last_event;
   } bcc_result_type;

   // controller -> datapath
   typedef struct packed {
      logic start;
      logic step;
      logic flush;
   } bcc_cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic ev_found;
      logic pend_valid;
      logic out_free;
   } bcc_status_type;

endpackage

// ===== design/bcc_req_if.sv =====
// Input channel: one tick with the sampled button levels.
`timescale 1ns / 1ps

interface bcc_req_if import bcc_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [MASK_WIDTH-1:0] button_levels;

   modport source (output valid, output button_levels, input ready);
   modport sink   (input valid, input button_levels, output ready);
endinterface

// ===== design/bcc_rsp_if.sv =====
// Result channel: one button event per transfer.
`timescale 1ns / 1ps

interface bcc_rsp_if;
   logic       valid;
   logic       ready;
   logic [2:0] button_index;
   logic [2:0] event_kind;
   logic [3:0] click_count;
   logic       last_event;

   modport source (output valid, output button_index, output event_kind,
                   output click_count, output last_event, input ready);
   modport sink   (input valid, input button_index, input event_kind,
                   input click_count, input last_event, output ready);
endinterface

// ===== design/bcc_ctrl.sv =====
// Scan controller: steps buttons one per cycle unless held; sequences the flush.
`timescale 1ns / 1ps

module bcc_ctrl import bcc_pkg::*; #(
   parameter int BUTTON_COUNT = DEF_BUTTON_COUNT,
   localparam int IDX_W = (BUTTON_COUNT > 1) ? $clog2(BUTTON_COUNT) : 1
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  bcc_status_type   status,
   output bcc_cmd_type      cmd,
   output logic [IDX_W-1:0] idx
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_FLUSH
   } state_type;

   localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(BUTTON_COUNT - 1);

   state_type        state_ff;
   logic [IDX_W-1:0] idx_ff;

   assign req_ready = (state_ff == ST_IDLE);
   assign idx       = idx_ff;

   always_comb begin
      cmd.start = (state_ff == ST_IDLE) && req_valid;
      // hold the scan while a new event would need the busy output slot
      cmd.step  = (state_ff == ST_SCAN) &&
                  (!status.ev_found || !status.pend_valid || status.out_free);
      cmd.flush = (state_ff == ST_FLUSH) && status.pend_valid && status.out_free;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         idx_ff   <= '0;
      end else begin
         case (state_ff)
            ST_IDLE: begin
               if (req_valid) begin
                  state_ff <= ST_SCAN;
                  idx_ff   <= '0;
               end
            end
            ST_SCAN: begin
               if (cmd.step) begin
                  if (idx_ff == IDX_LAST) begin
                     state_ff <= ST_FLUSH;
                  end else begin
                     idx_ff <= idx_ff + 1'b1;
                  end
               end
            end
            ST_FLUSH: begin
               if (!status.pend_valid || status.out_free) begin
                  state_ff <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

endmodule

// ===== design/bcc_dpath.sv =====
// Datapath: registers, per-button state, one-button step logic and result staging.
`timescale 1ns / 1ps

module bcc_dpath import bcc_pkg::*; #(
   parameter int BUTTON_COUNT = DEF_BUTTON_COUNT,
   parameter int COUNT_WIDTH  = DEF_COUNT_WIDTH,
   localparam int IDX_W = (BUTTON_COUNT > 1) ? $clog2(BUTTON_COUNT) : 1
) (
   input  logic                      clock,
   input  logic                      reset,
   input  bcc_cmd_type               cmd,
   input  logic [IDX_W-1:0]          idx,
   output bcc_status_type            status,
   input  logic [MASK_WIDTH-1:0]     levels,
   input  logic                      rsp_ready,
   output logic                      rsp_valid,
   output bcc_result_type            rsp_data,
   input  logic                      psel,
   input  logic                      penable,
   input  logic                      pwrite,
   input  logic [CSR_ADDR_WIDTH-1:0] paddr,
   input  logic [CSR_DATA_WIDTH-1:0] pwdata,
   output logic [CSR_DATA_WIDTH-1:0] prdata
);

   localparam int CMP_W  = (COUNT_WIDTH > TICK_REG_WIDTH) ? COUNT_WIDTH : TICK_REG_WIDTH;
   localparam int MASKED = (BUTTON_COUNT < MASK_WIDTH) ? BUTTON_COUNT : MASK_WIDTH;
   localparam logic [COUNT_WIDTH-1:0] CNT_MAX = {COUNT_WIDTH{1'b1}};

   // configuration registers
   logic [MASK_WIDTH-1:0]     enabled_ff, active_ff, paused_ff;
   logic [TICK_REG_WIDTH-1:0] click_ff, long_ff, vlong_ff, window_ff;

   // per-button state
   logic                   held_ff [BUTTON_COUNT];
   logic [3:0]             rep_ff  [BUTTON_COUNT];
   logic [COUNT_WIDTH-1:0] cnt_ff  [BUTTON_COUNT];

   logic [MASK_WIDTH-1:0] levels_ff;
   logic                  pend_valid_ff;
   bcc_event_type         pend_ff;
   logic                  out_valid_ff;
   bcc_result_type        out_ff;

   logic        csr_write;
   bcc_reg_type csr_reg;

   logic [5:0]             idx_wide;
   logic                   mask_sel;
   logic                   btn_live, btn_down;
   logic                   held_cur;
   logic [3:0]             rep_cur;
   logic [COUNT_WIDTH-1:0] cnt_cur, cnt_mv;
   logic [CMP_W-1:0]       cnt_cmp;
   logic [COUNT_WIDTH-1:0] window_sat;
   logic                   held_in;
   logic [3:0]             rep_in;
   logic [COUNT_WIDTH-1:0] cnt_in;
   logic                   kind_valid;
   bcc_kind_type           kind;
   bcc_event_type          ev_new;
   logic                   out_free;

   assign csr_write = psel && penable && pwrite;
   assign csr_reg   = bcc_reg_type'(paddr[4:2]);

   always_comb begin
      case (csr_reg)
         REG_ENABLED: prdata = CSR_DATA_WIDTH'(enabled_ff);
         REG_ACTIVE:  prdata = CSR_DATA_WIDTH'(active_ff);
         REG_PAUSED:  prdata = CSR_DATA_WIDTH'(paused_ff);
         REG_CLICK:   prdata = CSR_DATA_WIDTH'(click_ff);
         REG_LONG:    prdata = CSR_DATA_WIDTH'(long_ff);
         REG_VLONG:   prdata = CSR_DATA_WIDTH'(vlong_ff);
         REG_WINDOW:  prdata = CSR_DATA_WIDTH'(window_ff);
         default:     prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         enabled_ff <= '0;
         active_ff  <= '0;
         paused_ff  <= '0;
         click_ff   <= CLICK_TICKS_RESET;
         long_ff    <= LONG_TICKS_RESET;
         vlong_ff   <= VLONG_TICKS_RESET;
         window_ff  <= WINDOW_TICKS_RESET;
      end else if (csr_write) begin
         case (csr_reg)
            REG_ENABLED: enabled_ff <= pwdata[MASK_WIDTH-1:0];
            REG_ACTIVE:  active_ff  <= pwdata[MASK_WIDTH-1:0];
            REG_PAUSED:  paused_ff  <= pwdata[MASK_WIDTH-1:0];
            REG_CLICK:   click_ff   <= pwdata[TICK_REG_WIDTH-1:0];
            REG_LONG:    long_ff    <= pwdata[TICK_REG_WIDTH-1:0];
            REG_VLONG:   vlong_ff   <= pwdata[TICK_REG_WIDTH-1:0];
            REG_WINDOW:  window_ff  <= pwdata[TICK_REG_WIDTH-1:0];
            default: ;
         endcase
      end
   end

   // one button per cycle while the scan is not held: select its mask bits and state
   assign idx_wide = 6'(idx);
   assign mask_sel = (idx_wide < 6'(MASK_WIDTH));
   assign btn_live = mask_sel && enabled_ff[idx_wide[2:0]] && !paused_ff[idx_wide[2:0]];
   assign btn_down = mask_sel && (levels_ff[idx_wide[2:0]] == active_ff[idx_wide[2:0]]);

   assign held_cur = held_ff[idx];
   assign rep_cur  = rep_ff[idx];
   assign cnt_cur  = cnt_ff[idx];

   always_comb begin
      if (held_cur) begin
         cnt_mv = (cnt_cur != CNT_MAX) ? cnt_cur + 1'b1 : cnt_cur;
      end else begin
         cnt_mv = (cnt_cur != '0) ? cnt_cur - 1'b1 : cnt_cur;
      end
   end

   assign cnt_cmp    = CMP_W'(cnt_mv);
   assign window_sat = (CMP_W'(window_ff) > CMP_W'(CNT_MAX)) ? CNT_MAX
                                                             : COUNT_WIDTH'(window_ff);

   always_comb begin
      held_in    = held_cur;
      rep_in     = rep_cur;
      cnt_in     = cnt_mv;
      kind_valid = 1'b0;
      kind       = EV_PRESS;
      if (btn_down) begin
         if (held_cur) begin
            kind_valid = 1'b1;
            if (cnt_cmp == CMP_W'(click_ff)) begin
               kind = EV_PRESS;
            end else if (cnt_cmp == CMP_W'(long_ff)) begin
               kind = EV_LONG_PRESS;
            end else if (cnt_cmp == CMP_W'(vlong_ff)) begin
               kind = EV_VERY_LONG_PRESS;
            end else begin
               kind_valid = 1'b0;
            end
         end else begin
            // new press: count a repeat only inside the window
            if (cnt_mv != '0) begin
               rep_in = (rep_cur != REPEAT_MAX) ? rep_cur + 1'b1 : rep_cur;
            end else begin
               rep_in = '0;
            end
            held_in = 1'b1;
            cnt_in  = '0;
         end
      end else if (held_cur) begin
         kind_valid = 1'b1;
         if (cnt_cmp >= CMP_W'(vlong_ff)) begin
            kind = EV_VERY_LONG_CLICK;
         end else if (cnt_cmp >= CMP_W'(long_ff)) begin
            kind = EV_LONG_CLICK;
         end else if (cnt_cmp >= CMP_W'(click_ff)) begin
            kind = EV_CLICK;
         end else begin
            kind_valid = 1'b0;
         end
         held_in = 1'b0;
         cnt_in  = window_sat;
      end
   end

   assign ev_new.button_index = 3'(idx);
   assign ev_new.event_kind   = kind;
   assign ev_new.click_count  = rep_in;

   assign out_free          = !out_valid_ff || rsp_ready;
   assign status.ev_found   = btn_live && kind_valid;
   assign status.pend_valid = pend_valid_ff;
   assign status.out_free   = out_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int j = 0; j < BUTTON_COUNT; j++) begin
            held_ff[j] <= 1'b0;
            rep_ff[j]  <= '0;
            cnt_ff[j]  <= '0;
         end
      end else begin
         if (cmd.step && btn_live) begin
            held_ff[idx] <= held_in;
            rep_ff[idx]  <= rep_in;
            cnt_ff[idx]  <= cnt_in;
         end
         // a button that gets enabled restarts released
         if (csr_write && (csr_reg == REG_ENABLED)) begin
            for (int j = 0; j < MASKED; j++) begin
               if (pwdata[j] && !enabled_ff[j]) begin
                  held_ff[j] <= 1'b0;
                  rep_ff[j]  <= '0;
                  cnt_ff[j]  <= '0;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.start) begin
         levels_ff <= levels;
      end
   end

   // one event waits in the pending slot until we know whether it is the last
   always_ff @(posedge clock) begin
      if (reset) begin
         pend_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         if (cmd.step && status.ev_found) begin
            pend_valid_ff <= 1'b1;
         end else if (cmd.flush) begin
            pend_valid_ff <= 1'b0;
         end
         if ((cmd.step && status.ev_found && pend_valid_ff) || cmd.flush) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.step && status.ev_found) begin
         pend_ff <= ev_new;
         if (pend_valid_ff) begin
            out_ff.ev         <= pend_ff;
            out_ff.last_event <= 1'b0;
         end
      end else if (cmd.flush) begin
         out_ff.ev         <= pend_ff;
         out_ff.last_event <= 1'b1;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_ff;

endmodule

// ===== design/button_click_classifier_top.sv =====
// Top level of the button click classifier: controller, datapath and channel wiring.
`timescale 1ns / 1ps

// channel | dir | transfer                          | payload
// req     | in  | req.valid & req.ready             | button_levels
// rsp     | out | rsp.valid & rsp.ready             | button_index, event_kind,
//         |     |                                   | click_count, last_event
// csr     | in  | psel & penable & pwrite (APB)     | paddr, pwdata / prdata
//
// When results drain freely, the scan visits one button per cycle over the
// per-button state registers, then flushes the final event. A stalled result
// port holds the scan when a second event of the same tick needs the output
// slot, and holds the flush until the slot frees. Reset is synchronous and
// restores the controller state, configuration registers, button state and
// valid flags; there is no clearing pass.

module button_click_classifier_top import bcc_pkg::*; #(
   parameter int BUTTON_COUNT = DEF_BUTTON_COUNT,
   parameter int COUNT_WIDTH  = DEF_COUNT_WIDTH
) (
   input  logic                      clock,
   input  logic                      reset,
   bcc_req_if.sink                   req,
   bcc_rsp_if.source                 rsp,
   input  logic                      psel,
   input  logic                      penable,
   input  logic                      pwrite,
   input  logic [CSR_ADDR_WIDTH-1:0] paddr,
   input  logic [CSR_DATA_WIDTH-1:0] pwdata,
   output logic [CSR_DATA_WIDTH-1:0] prdata,
   output logic                      pready
);

   localparam int IDX_W = (BUTTON_COUNT > 1) ? $clog2(BUTTON_COUNT) : 1;

   bcc_cmd_type      cmd;
   bcc_status_type   status;
   logic [IDX_W-1:0] idx;
   bcc_result_type   rsp_data;

   assign pready = 1'b1;

   bcc_ctrl #(
      .BUTTON_COUNT(BUTTON_COUNT)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req.valid),
      .req_ready (req.ready),
      .status    (status),
      .cmd       (cmd),
      .idx       (idx)
   );

   bcc_dpath #(
      .BUTTON_COUNT(BUTTON_COUNT),
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_dpath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .idx       (idx),
      .status    (status),
      .levels    (req.button_levels),
      .rsp_ready (rsp.ready),
      .rsp_valid (rsp.valid),
      .rsp_data  (rsp_data),
      .psel      (psel),
      .penable   (penable),
      .pwrite    (pwrite),
      .paddr     (paddr),
      .pwdata    (pwdata),
      .prdata    (prdata)
   );

   assign rsp.button_index = rsp_data.ev.button_index;
   assign rsp.event_kind   = rsp_data.ev.event_kind;
   assign rsp.click_count  = rsp_data.ev.click_count;
   assign rsp.last_event   = rsp_data.last_event;

endmodule

// ===== design/bcc_checker.sv =====
// Port-level checks of the button click classifier, bound to the top level.
`timescale 1ns / 1ps
`include "button_click_classifier_top_macros.svh"

module bcc_checker import bcc_pkg::*; (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [2:0] rsp_button_index,
   input logic [2:0] rsp_event_kind,
   input logic [3:0] rsp_click_count,
   input logic       rsp_last_event
);

   // a stalled result holds its payload
   `BCC_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_button_index) && $stable(rsp_event_kind) && $stable(rsp_click_count) && $stable(rsp_last_event))

   // only the six defined event codes leave the block
   `BCC_ASSERT_NOW(a_kind_code, clock, reset, rsp_valid, rsp_event_kind <= EV_VERY_LONG_CLICK)

   // a tick is scanned before the next one is taken
   `BCC_ASSERT_NEXT(a_one_tick, clock, reset, req_valid && req_ready, !req_ready)

endmodule

bind button_click_classifier_top bcc_checker u_bcc_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req.valid),
   .req_ready        (req.ready),
   .rsp_valid        (rsp.valid),
   .rsp_ready        (rsp.ready),
   .rsp_button_index (rsp.button_index),
   .rsp_event_kind   (rsp.event_kind),
   .rsp_click_count  (rsp.click_count),
   .rsp_last_event   (rsp.last_event)
);
